// File: hdl/stint_pkg.sv
// ----------------------------------------------------------------------------
// stint_pkg
// Shared constants, status codes and control structs for the symbol table
// interning unit.
// ----------------------------------------------------------------------------
package stint_pkg;

   // Default geometry of the table
   localparam int TABLE_ENTRIES_DEF     = 256;
   localparam int FIRST_NUMBER_SLOT_DEF = 101;
   localparam int TEXT_LENGTH_DEF       = 16;

   // Result field widths
   localparam int ID_W     = 8;
   localparam int STATUS_W = 2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ADDED_ID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ADDED_NUM = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FAILED    = 2'd3;

   // Lookup request from the token assembler
   typedef struct packed {
      logic start;
      logic too_long;
   } scan_req_type;

   // Lookup answer back to the output stage
   typedef struct packed {
      logic                valid;
      logic [ID_W-1:0]     token_id;
      logic [STATUS_W-1:0] status;
   } scan_rsp_type;

endpackage

// File: hdl/symbol_table_interning_unit.sv
// ----------------------------------------------------------------------------
// symbol_table_interning_unit
// Interns tokens that arrive one byte per beat into a string table and
// returns the table id of each completed token.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one token byte per beat in req_tdata[7:0]; req_tlast marks
//   the final byte. Bytes of a token are taken one per cycle. After the last
//   byte, req_tready stays low through the search until the answer enters the output register.
//   rsp_* returns one beat per token: id in [7:0], status in [9:8]
//   (found, added identifier, added number, failed).
//   Search: the table memory is read one occupied entry per cycle, stopping
//   at a hit; at most TABLE_ENTRIES - 1 entries are read per token. The
//   answer passes the scan result registers and then the rsp output
//   register. The single read port of the table limits how fast tokens
//   are answered.
//   While a result waits on rsp, bytes of the next token are still taken;
//   the next search finishes and then waits until rsp_tready frees the
//   output register.
//   Reset empties the table (slot counters back to their first slots) and
//   drops any partial token; no clearing pass is needed.
// ----------------------------------------------------------------------------
module symbol_table_interning_unit
   import stint_pkg::*;
#(
   parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
   parameter int FIRST_NUMBER_SLOT = FIRST_NUMBER_SLOT_DEF,
   parameter int TEXT_LENGTH       = TEXT_LENGTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] token_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] token_id, [9:8] status, [15:10] zero
);

   localparam int TEXT_MAX = TEXT_LENGTH - 1;
   localparam int LEN_W    = $clog2(TEXT_LENGTH);
   localparam int TOK_W    = 8 * TEXT_MAX;

   localparam logic [LEN_W-1:0] TEXT_MAX_C = LEN_W'(TEXT_MAX);

   logic                req_accept;
   logic                rsp_load;
   logic                busy_ff, busy_in;
   logic                start_ff, start_in;
   logic [LEN_W-1:0]    tok_len_ff, tok_len_in;
   logic                too_long_ff, too_long_in;
   logic [7:0]          tok_buf_ff [TEXT_MAX];
   logic [TOK_W-1:0]    tok_flat;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   scan_req_type        scan_req;
   scan_rsp_type        scan_rsp;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = scan_rsp.valid && (!rsp_valid_ff || rsp_tready);

   // Assemble the token; drop bytes past the text limit and flag it
   always_comb begin
      tok_len_in  = tok_len_ff;
      too_long_in = too_long_ff;
      busy_in     = busy_ff;
      start_in    = 1'b0;
      if (req_accept) begin
         if (tok_len_ff < TEXT_MAX_C) begin
            tok_len_in = tok_len_ff + LEN_W'(1);
         end else begin
            too_long_in = 1'b1;
         end
         if (req_tlast) begin
            busy_in  = 1'b1;
            start_in = 1'b1;
         end
      end
      if (rsp_load) begin
         tok_len_in  = '0;
         too_long_in = 1'b0;
         busy_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < TEXT_MAX; j++) begin
         if (req_accept && tok_len_ff == LEN_W'(j)) begin
            tok_buf_ff[j] <= req_tdata;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < TEXT_MAX; j++) begin
         tok_flat[8*j +: 8] = tok_buf_ff[j];
      end
   end

   assign scan_req.start    = start_ff;
   assign scan_req.too_long = too_long_ff;

   stint_scan #(
      .TABLE_ENTRIES     (TABLE_ENTRIES),
      .FIRST_NUMBER_SLOT (FIRST_NUMBER_SLOT),
      .TEXT_LENGTH       (TEXT_LENGTH)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .req     (scan_req),
      .tok_len (tok_len_ff),
      .tok_buf (tok_flat),
      .take    (rsp_load),
      .rsp     (scan_rsp)
   );

   // Output register: load a finished answer when the slot is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_id_ff     <= scan_rsp.token_id;
         rsp_status_ff <= scan_rsp.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         tok_len_ff   <= '0;
         too_long_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         tok_len_ff   <= tok_len_in;
         too_long_ff  <= too_long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_id_ff};

endmodule

// File: hdl/stint_scan.sv
// ----------------------------------------------------------------------------
// stint_scan
// Table memory and lookup engine: walks the occupied entries one per cycle and
// reports a hit, else appends the token to its region or reports a failure.
// ----------------------------------------------------------------------------
module stint_scan
   import stint_pkg::*;
#(
   parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
   parameter int FIRST_NUMBER_SLOT = FIRST_NUMBER_SLOT_DEF,
   parameter int TEXT_LENGTH       = TEXT_LENGTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  scan_req_type                          req,
   input  logic [$clog2(TEXT_LENGTH)-1:0]        tok_len,
   input  logic [8*(TEXT_LENGTH-1)-1:0]          tok_buf,
   input  logic                                  take,
   output scan_rsp_type                          rsp
);

   localparam int TEXT_MAX = TEXT_LENGTH - 1;
   localparam int LEN_W    = $clog2(TEXT_LENGTH);
   localparam int TOK_W    = 8 * TEXT_MAX;
   localparam int ENT_W    = LEN_W + TOK_W;
   localparam int IDX_W    = $clog2(TABLE_ENTRIES);
   localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int SPLIT    = (FIRST_NUMBER_SLOT < TABLE_ENTRIES) ?
                             FIRST_NUMBER_SLOT : TABLE_ENTRIES;

   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
   localparam logic [CNT_W-1:0] SPLIT_C = CNT_W'(SPLIT);
   localparam logic [CNT_W-1:0] TABLE_C = CNT_W'(TABLE_ENTRIES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // Entry store: {length, text}, one entry per word
   logic [ENT_W-1:0]    mem_q [TABLE_ENTRIES];
   logic [ENT_W-1:0]    rd_data_ff;
   logic                mem_we;
   logic [CNT_W-1:0]    mem_wa;
   logic                mem_re;
   logic [CNT_W-1:0]    mem_ra;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    next_id_ff, next_id_in;
   logic [CNT_W-1:0]    next_num_ff, next_num_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic                issue_ff, issue_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [CNT_W-1:0]    chk_ptr_ff, chk_ptr_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic [LEN_W-1:0]    rd_len;
   logic                bytes_eq;
   logic                match;
   logic [CNT_W-1:0]    ptr_step;
   logic [7:0]          first_byte;

   // Write on insert, registered read for the scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[mem_wa[IDX_W-1:0]] <= {tok_len, tok_buf};
      end
      if (mem_re) begin
         rd_data_ff <= mem_q[mem_ra[IDX_W-1:0]];
      end
   end

   // Compare the entry read last cycle against the assembled token
   always_comb begin
      rd_len   = rd_data_ff[ENT_W-1 -: LEN_W];
      bytes_eq = 1'b1;
      for (int j = 0; j < TEXT_MAX; j++) begin
         if (j < int'(tok_len) && rd_data_ff[8*j +: 8] != tok_buf[8*j +: 8]) begin
            bytes_eq = 1'b0;
         end
      end
      match = (rd_len == tok_len) && bytes_eq;
   end

   // Next occupied entry: identifiers first, then jump to the number region
   assign ptr_step   = (ptr_ff + ONE_C == next_id_ff) ? SPLIT_C : ptr_ff + ONE_C;
   assign first_byte = tok_buf[7:0];

   always_comb begin
      state_in      = state_ff;
      next_id_in    = next_id_ff;
      next_num_in   = next_num_ff;
      ptr_in        = ptr_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_ptr_in    = chk_ptr_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_wa        = next_id_ff;
      mem_re        = 1'b0;
      mem_ra        = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               if (req.too_long) begin
                  res_id_in     = '0;
                  res_status_in = ST_FAILED;
                  state_in      = S_DONE;
               end else begin
                  if (next_id_ff != ONE_C) begin
                     ptr_in   = ONE_C;
                     issue_in = 1'b1;
                  end else begin
                     ptr_in   = SPLIT_C;
                     issue_in = (next_num_ff != SPLIT_C);
                  end
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (chk_valid_ff && match) begin
               // Hit: report the entry just compared
               res_id_in     = ID_W'(chk_ptr_ff);
               res_status_in = ST_FOUND;
               state_in      = S_DONE;
            end else if (issue_ff) begin
               // Read the next occupied entry
               mem_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_ptr_in   = ptr_ff;
               ptr_in       = ptr_step;
               issue_in     = (ptr_step != next_num_ff);
            end else begin
               // Miss: append to the region chosen by the first byte, or fail if none fits
               if (is_letter(first_byte) && next_id_ff < SPLIT_C) begin
                  mem_we        = 1'b1;
                  mem_wa        = next_id_ff;
                  res_id_in     = ID_W'(next_id_ff);
                  res_status_in = ST_ADDED_ID;
                  next_id_in    = next_id_ff + ONE_C;
               end else if (is_digit(first_byte) && next_num_ff < TABLE_C) begin
                  mem_we        = 1'b1;
                  mem_wa        = next_num_ff;
                  res_id_in     = ID_W'(next_num_ff);
                  res_status_in = ST_ADDED_NUM;
                  next_num_in   = next_num_ff + ONE_C;
               end else begin
                  res_id_in     = '0;
                  res_status_in = ST_FAILED;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_id_ff   <= ONE_C;
         next_num_ff  <= SPLIT_C;
         issue_ff     <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         next_num_ff  <= next_num_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      chk_ptr_ff    <= chk_ptr_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
   end

   assign rsp.valid    = (state_ff == S_DONE);
   assign rsp.token_id = res_id_ff;
   assign rsp.status   = res_status_ff;

   // Slot counters stay inside their regions
   a_counters_bounded: assert property (@(posedge clock) disable iff (reset)
      next_id_ff <= SPLIT_C && next_num_ff >= SPLIT_C && next_num_ff <= TABLE_C)
      else $error("slot counter left its region");

   // A failed lookup never carries an id
   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == ST_FAILED |-> rsp.token_id == '0)
      else $error("failed result with nonzero id");

   // A new lookup only starts when the engine is idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == S_IDLE)
      else $error("lookup started while busy");

   // The table is written only at the end of a scan
   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == S_SCAN && !mem_re)
      else $error("table write outside scan");

   // A waiting answer holds until taken
   a_hold_answer: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !take |=> rsp.valid && $stable(rsp.token_id) && $stable(rsp.status))
      else $error("answer changed before handoff");

endmodule
